>>> rtl/core/hbu_pkg.sv
`timescale 1ns / 1ps

package hbu_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_GRID_SIDE     = 3'd0,
    REG_SUBSAMPLING   = 3'd1,
    REG_VERTEX_COUNT  = 3'd2,
    REG_HEIGHT_SCALE  = 3'd3,
    REG_FLIP_ROWS     = 3'd4,
    REG_INVERT_HEIGHT = 3'd5,
    REG_MIN_ELEVATION = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [8:0]         grid_side;
    logic [4:0]         subsampling;
    logic [12:0]        vertex_count;
    logic signed [15:0] height_scale;
    logic               flip_rows;
    logic               invert_height;
    logic signed [31:0] min_elevation;
  } cfg_t;

  typedef logic [32:0] recip_t;

  // ceil(2^32 / s); quotient = (v * r) >> 32 is exact for v below 2^21
  localparam recip_t RECIP_TBL [32] = '{
    33'd0,
    33'(64'hFFFF_FFFF / 64'd1  + 64'd1), 33'(64'hFFFF_FFFF / 64'd2  + 64'd1),
    33'(64'hFFFF_FFFF / 64'd3  + 64'd1), 33'(64'hFFFF_FFFF / 64'd4  + 64'd1),
    33'(64'hFFFF_FFFF / 64'd5  + 64'd1), 33'(64'hFFFF_FFFF / 64'd6  + 64'd1),
    33'(64'hFFFF_FFFF / 64'd7  + 64'd1), 33'(64'hFFFF_FFFF / 64'd8  + 64'd1),
    33'(64'hFFFF_FFFF / 64'd9  + 64'd1), 33'(64'hFFFF_FFFF / 64'd10 + 64'd1),
    33'(64'hFFFF_FFFF / 64'd11 + 64'd1), 33'(64'hFFFF_FFFF / 64'd12 + 64'd1),
    33'(64'hFFFF_FFFF / 64'd13 + 64'd1), 33'(64'hFFFF_FFFF / 64'd14 + 64'd1),
    33'(64'hFFFF_FFFF / 64'd15 + 64'd1), 33'(64'hFFFF_FFFF / 64'd16 + 64'd1),
    33'(64'hFFFF_FFFF / 64'd17 + 64'd1), 33'(64'hFFFF_FFFF / 64'd18 + 64'd1),
    33'(64'hFFFF_FFFF / 64'd19 + 64'd1), 33'(64'hFFFF_FFFF / 64'd20 + 64'd1),
    33'(64'hFFFF_FFFF / 64'd21 + 64'd1), 33'(64'hFFFF_FFFF / 64'd22 + 64'd1),
    33'(64'hFFFF_FFFF / 64'd23 + 64'd1), 33'(64'hFFFF_FFFF / 64'd24 + 64'd1),
    33'(64'hFFFF_FFFF / 64'd25 + 64'd1), 33'(64'hFFFF_FFFF / 64'd26 + 64'd1),
    33'(64'hFFFF_FFFF / 64'd27 + 64'd1), 33'(64'hFFFF_FFFF / 64'd28 + 64'd1),
    33'(64'hFFFF_FFFF / 64'd29 + 64'd1), 33'(64'hFFFF_FFFF / 64'd30 + 64'd1),
    33'(64'hFFFF_FFFF / 64'd31 + 64'd1)
  };

endpackage

>>> rtl/core/hbu_ram.sv
`timescale 1ns / 1ps

module hbu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/hbu_cfg.sv
`timescale 1ns / 1ps

module hbu_cfg
  import hbu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_side     <= 9'd257;
      cfg_r.subsampling   <= 5'd1;
      cfg_r.vertex_count  <= 13'd257;
      cfg_r.height_scale  <= 16'sd256;
      cfg_r.flip_rows     <= 1'b0;
      cfg_r.invert_height <= 1'b0;
      cfg_r.min_elevation <= 32'sd0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_GRID_SIDE:     cfg_r.grid_side     <= pwdata[8:0];
        REG_SUBSAMPLING:   cfg_r.subsampling   <= pwdata[4:0];
        REG_VERTEX_COUNT:  cfg_r.vertex_count  <= pwdata[12:0];
        REG_HEIGHT_SCALE:  cfg_r.height_scale  <= $signed(pwdata[15:0]);
        REG_FLIP_ROWS:     cfg_r.flip_rows     <= pwdata[0];
        REG_INVERT_HEIGHT: cfg_r.invert_height <= pwdata[0];
        REG_MIN_ELEVATION: cfg_r.min_elevation <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GRID_SIDE:     prdata = 32'(cfg_r.grid_side);
      REG_SUBSAMPLING:   prdata = 32'(cfg_r.subsampling);
      REG_VERTEX_COUNT:  prdata = 32'(cfg_r.vertex_count);
      REG_HEIGHT_SCALE:  prdata = 32'($unsigned(cfg_r.height_scale));
      REG_FLIP_ROWS:     prdata = 32'(cfg_r.flip_rows);
      REG_INVERT_HEIGHT: prdata = 32'(cfg_r.invert_height);
      REG_MIN_ELEVATION: prdata = $unsigned(cfg_r.min_elevation);
      default:           prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/core/heightmap_bilinear_upsampler.sv
`timescale 1ns / 1ps

// Bilinear heightmap upsampler.
// Input channel (in_*): each word is either a grid write (opcode 0: store
// in_sample_value at in_grid_index) or a vertex query (opcode 1: vertex_x,
// vertex_y). Writes produce no output word; every query produces exactly one.
// Output channel (out_*): interpolated, scaled and saturated height, output
// array index (row flipped if enabled) and an out_of_range flag (height and
// index read zero when set).
// Configuration: APB registers at byte offsets 0x00..0x18 (grid_side,
// subsampling, vertex_count, height_scale, flip_rows, invert_height,
// min_elevation). Write them only while the block is drained.
// Throughput: one word per clock while out_stall does not hold the output word. A
// query passes twelve register stages counting the output word; the grid read sits
// in the middle and uses four copies of the sample store, one per corner.
// Host must write every grid cell before a query reads it.
// Stall: when out_valid is high and out_stall is asserted, the whole pipeline
// holds and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (rst_n low, synchronous): empties the pipeline and restores register
// defaults; sample store contents are left as they are.

module heightmap_bilinear_upsampler
  import hbu_pkg::*;
#(
  parameter int MAX_SIDE    = 257,
  parameter int MAX_VERTS   = 4096,
  parameter int HEIGHT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [16:0]        in_grid_index,
  input  logic signed [31:0] in_sample_value,
  input  logic [11:0]        in_vertex_x,
  input  logic [11:0]        in_vertex_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_height,
  output logic [23:0]        out_dest_index,
  output logic               out_out_of_range
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [49:0] HMAX = 50'((64'sd1 <<< (HEIGHT_BITS - 1)) - 64'sd1);
  localparam logic signed [49:0] HMIN = -HMAX - 50'sd1;

  cfg_t cfg;

  hbu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Effective limits: saturate registers to what the store and index allow
  logic [12:0] side_w;
  logic [14:0] vc_w;
  recip_t      recip_w;

  assign side_w  = (13'(cfg.grid_side) > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : 13'(cfg.grid_side);
  assign vc_w    = (15'(cfg.vertex_count) > 15'(MAX_VERTS)) ? 15'(MAX_VERTS)
                                                             : 15'(cfg.vertex_count);
  assign recip_w = RECIP_TBL[cfg.subsampling];

  // Whole pipeline advances together unless the output word is blocked
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage valids ----------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic s7_v_r, s8_v_r, s9_v_r, s10_v_r, s11_v_r, out_v_r;

  // ---------------- stage payloads ----------------
  op_t                s1_op_r, s2_op_r, s3_op_r, s4_op_r;
  logic [16:0]        s1_gi_r, s2_gi_r, s3_gi_r, s4_gi_r;
  logic signed [31:0] s1_sv_r, s2_sv_r, s3_sv_r, s4_sv_r;
  logic [11:0]        s1_x_r, s1_y_r, s2_x_r;
  logic [44:0]        s1_px_r, s1_py_r;
  logic [11:0]        s2_xq_r, s2_yq_r;
  logic [4:0]         s2_rx_r, s2_ry_r;
  logic [14:0]        s2_row_r;
  logic               s2_oor_r, s3_oor_r, s4_oor_r, s5_oor_r, s6_oor_r;
  logic               s7_oor_r, s8_oor_r, s9_oor_r, s10_oor_r, s11_oor_r;
  logic [15:0]        s3_fx_r, s3_fy_r, s4_fx_r, s4_fy_r, s5_fx_r, s5_fy_r;
  logic [15:0]        s6_fy_r, s7_fy_r;
  logic [12:0]        s3_x1_r, s3_x2_r, s3_y1_r, s3_y2_r;
  logic [23:0]        s3_dst_r, s4_dst_r, s5_dst_r, s6_dst_r, s7_dst_r;
  logic [23:0]        s8_dst_r, s9_dst_r, s10_dst_r, s11_dst_r;
  logic [AW-1:0]      s4_a00_r, s4_a01_r, s4_a10_r, s4_a11_r;
  logic signed [49:0] s6_m0_r, s6_m1_r;
  logic signed [31:0] s6_p00_r, s6_p10_r;
  logic signed [32:0] s7_h1_r, s7_h2_r, s8_h1_r;
  logic signed [50:0] s8_mh_r;
  logic signed [33:0] s9_h_r;
  logic signed [50:0] s10_ms_r;
  logic signed [43:0] s11_s_r;
  logic signed [31:0] out_height_r;
  logic [23:0]        out_dst_r;
  logic               out_oor_r;

  // ---------------- combinational per stage ----------------
  logic [11:0]        qx_w, qy_w;
  logic [4:0]         rx_w, ry_w;
  logic               oor_w;
  logic [14:0]        row_w;
  logic [37:0]        fxp_w, fyp_w;
  logic [12:0]        x2i_w, y2i_w;
  logic [28:0]        dst_w;
  logic [25:0]        r1_w, r2_w;
  logic signed [31:0] p00_w, p01_w, p10_w, p11_w;
  logic signed [32:0] d0_w, d1_w;
  logic signed [33:0] dh_w;
  logic signed [34:0] hm_w;
  logic signed [44:0] t_w;
  logic signed [49:0] te_w;
  logic               ram_we;

  assign qx_w = s1_px_r[43:32];
  assign qy_w = s1_py_r[43:32];
  assign rx_w = 5'(17'(s1_x_r) - 17'(qx_w) * 17'(cfg.subsampling));
  assign ry_w = 5'(17'(s1_y_r) - 17'(qy_w) * 17'(cfg.subsampling));
  assign oor_w = (cfg.subsampling == 5'd0) || (15'(s1_x_r) >= vc_w) ||
                 (15'(s1_y_r) >= vc_w) || (13'(qx_w) >= side_w) || (13'(qy_w) >= side_w);
  assign row_w = cfg.flip_rows ? 15'(vc_w - 15'd1 - 15'(s1_y_r)) : 15'(s1_y_r);

  assign fxp_w = 38'(s2_rx_r) * 38'(recip_w);
  assign fyp_w = 38'(s2_ry_r) * 38'(recip_w);
  assign x2i_w = 13'(s2_xq_r) + 13'(s2_rx_r != 5'd0);
  assign y2i_w = 13'(s2_yq_r) + 13'(s2_ry_r != 5'd0);
  assign dst_w = 29'(s2_row_r) * 29'(vc_w) + 29'(s2_x_r);

  assign r1_w = 26'(s3_y1_r) * 26'(side_w);
  assign r2_w = 26'(s3_y2_r) * 26'(side_w);

  // Write and read the store at the same stage so program order holds
  assign ram_we = adv && s4_v_r && (s4_op_r == OP_WRITE) &&
                  ({15'd0, s4_gi_r} < 32'(DEPTH));

  hbu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram00 (
    .clk(clk), .we(ram_we), .waddr(AW'(s4_gi_r)), .wdata(s4_sv_r),
    .re(adv), .raddr(s4_a00_r), .rdata(p00_w)
  );
  hbu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram01 (
    .clk(clk), .we(ram_we), .waddr(AW'(s4_gi_r)), .wdata(s4_sv_r),
    .re(adv), .raddr(s4_a01_r), .rdata(p01_w)
  );
  hbu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram10 (
    .clk(clk), .we(ram_we), .waddr(AW'(s4_gi_r)), .wdata(s4_sv_r),
    .re(adv), .raddr(s4_a10_r), .rdata(p10_w)
  );
  hbu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram11 (
    .clk(clk), .we(ram_we), .waddr(AW'(s4_gi_r)), .wdata(s4_sv_r),
    .re(adv), .raddr(s4_a11_r), .rdata(p11_w)
  );

  assign d0_w = 33'(p01_w) - 33'(p00_w);
  assign d1_w = 33'(p11_w) - 33'(p10_w);
  assign dh_w = 34'(s7_h2_r) - 34'(s7_h1_r);
  assign hm_w = 35'(s9_h_r) - 35'(cfg.min_elevation);

  // Invert, or clamp up to the minimum, then saturate to HEIGHT_BITS
  assign t_w  = cfg.invert_height ? -45'(s11_s_r) :
                ((s11_s_r < 44'(cfg.min_elevation)) ? 45'(cfg.min_elevation)
                                                    : 45'(s11_s_r));
  assign te_w = (50'(t_w) > HMAX) ? HMAX : ((50'(t_w) < HMIN) ? HMIN : 50'(t_w));

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
      s11_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      // drop write words once they reach the store
      s5_v_r  <= s4_v_r && (s4_op_r == OP_QUERY);
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
      s10_v_r <= s9_v_r;
      s11_v_r <= s10_v_r;
      out_v_r <= s11_v_r;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      // S1: capture, reciprocal multiply for the cell division
      s1_op_r <= op_t'(in_opcode);
      s1_gi_r <= in_grid_index;
      s1_sv_r <= in_sample_value;
      s1_x_r  <= in_vertex_x;
      s1_y_r  <= in_vertex_y;
      s1_px_r <= 45'(in_vertex_x) * 45'(recip_w);
      s1_py_r <= 45'(in_vertex_y) * 45'(recip_w);
      // S2: quotient, remainder, range checks, output row
      s2_op_r  <= s1_op_r;
      s2_gi_r  <= s1_gi_r;
      s2_sv_r  <= s1_sv_r;
      s2_x_r   <= s1_x_r;
      s2_xq_r  <= qx_w;
      s2_yq_r  <= qy_w;
      s2_rx_r  <= rx_w;
      s2_ry_r  <= ry_w;
      s2_oor_r <= oor_w;
      s2_row_r <= row_w;
      // S3: fractions, far neighbors clamped to side-1, output index
      s3_op_r  <= s2_op_r;
      s3_gi_r  <= s2_gi_r;
      s3_sv_r  <= s2_sv_r;
      s3_oor_r <= s2_oor_r;
      s3_fx_r  <= fxp_w[31:16];
      s3_fy_r  <= fyp_w[31:16];
      s3_x1_r  <= 13'(s2_xq_r);
      s3_y1_r  <= 13'(s2_yq_r);
      s3_x2_r  <= (x2i_w >= side_w) ? side_w - 13'd1 : x2i_w;
      s3_y2_r  <= (y2i_w >= side_w) ? side_w - 13'd1 : y2i_w;
      s3_dst_r <= dst_w[23:0];
      // S4: corner addresses
      s4_op_r  <= s3_op_r;
      s4_gi_r  <= s3_gi_r;
      s4_sv_r  <= s3_sv_r;
      s4_oor_r <= s3_oor_r;
      s4_fx_r  <= s3_fx_r;
      s4_fy_r  <= s3_fy_r;
      s4_dst_r <= s3_dst_r;
      s4_a00_r <= AW'(r1_w + 26'(s3_x1_r));
      s4_a01_r <= AW'(r1_w + 26'(s3_x2_r));
      s4_a10_r <= AW'(r2_w + 26'(s3_x1_r));
      s4_a11_r <= AW'(r2_w + 26'(s3_x2_r));
      // S5: store read data lands in the RAM output registers
      s5_oor_r <= s4_oor_r;
      s5_fx_r  <= s4_fx_r;
      s5_fy_r  <= s4_fy_r;
      s5_dst_r <= s4_dst_r;
      // S6: horizontal difference times fx
      s6_oor_r <= s5_oor_r;
      s6_fy_r  <= s5_fy_r;
      s6_dst_r <= s5_dst_r;
      s6_p00_r <= p00_w;
      s6_p10_r <= p10_w;
      s6_m0_r  <= 50'(d0_w) * 50'($signed({1'b0, s5_fx_r}));
      s6_m1_r  <= 50'(d1_w) * 50'($signed({1'b0, s5_fx_r}));
      // S7: round and add, row interpolants
      s7_oor_r <= s6_oor_r;
      s7_fy_r  <= s6_fy_r;
      s7_dst_r <= s6_dst_r;
      s7_h1_r  <= 33'(s6_p00_r) + 33'((s6_m0_r + 50'sd32768) >>> 16);
      s7_h2_r  <= 33'(s6_p10_r) + 33'((s6_m1_r + 50'sd32768) >>> 16);
      // S8: vertical difference times fy
      s8_oor_r <= s7_oor_r;
      s8_dst_r <= s7_dst_r;
      s8_h1_r  <= s7_h1_r;
      s8_mh_r  <= 51'(dh_w) * 51'($signed({1'b0, s7_fy_r}));
      // S9: interpolated height
      s9_oor_r <= s8_oor_r;
      s9_dst_r <= s8_dst_r;
      s9_h_r   <= 34'(s8_h1_r) + 34'((s8_mh_r + 51'sd32768) >>> 16);
      // S10: relative height times scale
      s10_oor_r <= s9_oor_r;
      s10_dst_r <= s9_dst_r;
      s10_ms_r  <= 51'(hm_w) * 51'(cfg.height_scale);
      // S11: drop the Q8.8 scale's fraction bits, back around the minimum
      s11_oor_r <= s10_oor_r;
      s11_dst_r <= s10_dst_r;
      s11_s_r   <= 44'(cfg.min_elevation) + 44'((s10_ms_r + 51'sd128) >>> 8);
      // Output word: zero payload for out-of-range queries
      out_oor_r    <= s11_oor_r;
      out_dst_r    <= s11_oor_r ? 24'd0 : s11_dst_r;
      out_height_r <= s11_oor_r ? 32'sd0 : 32'(te_w);
    end
  end

  assign out_valid        = out_v_r;
  assign out_height       = out_height_r;
  assign out_dest_index   = out_dst_r;
  assign out_out_of_range = out_oor_r;

  // ---------------- assertions ----------------
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_height == 32'sd0 && out_dest_index == 24'd0))
    else $error("out-of-range word carries a nonzero payload");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input held off without a blocked output word");

  a_query_to_store: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s4_v_r && s4_op_r == OP_QUERY) |=> s5_v_r)
    else $error("query lost at the store read stage");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> !s5_v_r)
    else $error("grid write produced a pipeline result slot");

endmodule
